/* rtl/deadline_sorted_timer_queue_assert.svh */
// Assertion macros for the deadline sorted timer queue.
// Used by the top level; needs no package.
`ifndef DEADLINE_SORTED_TIMER_QUEUE_ASSERT_SVH
`define DEADLINE_SORTED_TIMER_QUEUE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled while reset is active.
`define TDQ_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("timer queue assertion failed");

// Next-cycle implication, disabled while reset is active.
`define TDQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("timer queue assertion failed");

`else

`define TDQ_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define TDQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

/* rtl/tdq_pkg.sv */
// Shared types, codes and helpers for the deadline sorted timer queue.
// No dependencies; imported by every module of the block.
package tdq_pkg;

    // Default sizes and fixed field widths.
    localparam int DEF_CAPACITY  = 16;
    localparam int DEF_TIME_BITS = 48;
    localparam int MAX_FIRE      = 16;
    localparam int IN_TIME_W     = 48;
    localparam int ID_W          = 32;
    localparam int DEST_W        = 16;
    localparam int PAY_W         = 32;
    localparam int ENTRY_FIXED_W = ID_W + DEST_W + PAY_W;

    // Request opcodes.
    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_DELETE = 2'd1;
    localparam logic [1:0] OP_TICK   = 2'd2;

    // Result status codes.
    localparam logic [2:0] ST_ADDED    = 3'd0;
    localparam logic [2:0] ST_FULL     = 3'd1;
    localparam logic [2:0] ST_DELETED  = 3'd2;
    localparam logic [2:0] ST_NOTFOUND = 3'd3;
    localparam logic [2:0] ST_FIRED    = 3'd4;

    // One input request.
    typedef struct packed {
        logic [1:0]           opcode;
        logic [IN_TIME_W-1:0] deadline;
        logic [DEST_W-1:0]    destination;
        logic [PAY_W-1:0]     payload;
        logic [ID_W-1:0]      target_id;
        logic [IN_TIME_W-1:0] current_time;
    } tdq_in_t;

    // One result.
    typedef struct packed {
        logic [2:0]        status;
        logic [ID_W-1:0]   result_id;
        logic [DEST_W-1:0] fired_destination;
        logic [PAY_W-1:0]  fired_payload;
        logic              last;
    } tdq_out_t;

    // Flags from the shared compare unit.
    typedef struct packed {
        logic gt;
        logic lt;
        logic id_eq;
    } tdq_cmp_t;

    // Assemble a result item.
    function automatic tdq_out_t tdq_result(input logic [2:0]        status,
                                            input logic [ID_W-1:0]   id,
                                            input logic [DEST_W-1:0] dest,
                                            input logic [PAY_W-1:0]  pay,
                                            input logic              last);
        tdq_out_t r;
        r.status            = status;
        r.result_id         = id;
        r.fired_destination = dest;
        r.fired_payload     = pay;
        r.last              = last;
        return r;
    endfunction

endpackage

/* rtl/tdq_ram.sv */
// Entry store of the timer queue: one write port, one read port, registered read.
// Depends on tdq_pkg for default sizes.
module tdq_ram
    import tdq_pkg::*;
#(
    parameter int DEPTH  = DEF_CAPACITY,
    parameter int DATA_W = DEF_TIME_BITS + ENTRY_FIXED_W
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DATA_W-1:0]        wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    // Write and registered read.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/tdq_cmp.sv */
// Shared compare unit: deadline magnitude compare and id match for one entry.
// Depends on tdq_pkg for the flag struct and id width.
module tdq_cmp
    import tdq_pkg::*;
#(
    parameter int TIME_BITS = DEF_TIME_BITS
) (
    input  logic [TIME_BITS-1:0] entry_deadline,
    input  logic [TIME_BITS-1:0] key_time,
    input  logic [ID_W-1:0]      entry_id,
    input  logic [ID_W-1:0]      match_id,
    output tdq_cmp_t             res
);

    // One comparator serves insert search (later) and tick (earlier).
    always_comb begin
        res.gt    = entry_deadline > key_time;
        res.lt    = entry_deadline < key_time;
        res.id_eq = entry_id == match_id;
    end

endmodule

/* rtl/tdq_ctrl.sv */
// Sequencer of the timer queue: walks the entry store one entry at a time
// through the shared compare unit. Depends on tdq_pkg, tdq_ram and tdq_cmp.
module tdq_ctrl
    import tdq_pkg::*;
#(
    parameter int CAPACITY  = DEF_CAPACITY,
    parameter int TIME_BITS = DEF_TIME_BITS
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  tdq_in_t  s_item,
    output logic     emit_valid,
    output tdq_out_t emit_item,
    input  logic     emit_take
);

    localparam int AW       = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int ENTRY_W  = TIME_BITS + ENTRY_FIXED_W;
    localparam int DEST_LSB = PAY_W;
    localparam int ID_LSB   = PAY_W + DEST_W;
    localparam int DL_LSB   = ID_LSB + ID_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_AREAD,
        S_AEVAL,
        S_AINS,
        S_DREAD,
        S_DEVAL,
        S_TREAD,
        S_TEVAL,
        S_TLAST,
        S_FINISH
    } state_t;

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [ID_W-1:0]      next_id_reg, next_id_next;
    logic [AW-1:0]        idx_reg, idx_next;
    logic [AW-1:0]        ins_addr_reg, ins_addr_next;
    logic [CNT_W-1:0]     fire_n_reg, fire_n_next;
    logic                 found_reg, found_next;
    logic                 firing_reg, firing_next;
    logic                 pend_reg, pend_next;
    logic [TIME_BITS-1:0] key_reg, key_next;
    logic [ID_W-1:0]      op_id_reg, op_id_next;
    logic [DEST_W-1:0]    new_dest_reg, new_dest_next;
    logic [PAY_W-1:0]     new_pay_reg, new_pay_next;
    logic [ID_W-1:0]      pend_id_reg, pend_id_next;
    logic [DEST_W-1:0]    pend_dest_reg, pend_dest_next;
    logic [PAY_W-1:0]     pend_pay_reg, pend_pay_next;
    tdq_out_t             fin_item_reg, fin_item_next;
    logic                 emit_valid_reg, emit_valid_next;
    tdq_out_t             emit_item_reg, emit_item_next;

    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic [ENTRY_W-1:0]   mem_wdata;
    logic [ENTRY_W-1:0]   rdata;
    logic [TIME_BITS-1:0] rd_deadline;
    logic [ID_W-1:0]      rd_id;
    logic [DEST_W-1:0]    rd_dest;
    logic [PAY_W-1:0]     rd_pay;
    tdq_cmp_t             cmp_res;
    logic                 slot_free;
    logic                 last_idx;
    logic                 found_now;
    logic                 fire_ok;

    // Entry store, read at the scan index.
    tdq_ram #(
        .DEPTH  (CAPACITY),
        .DATA_W (ENTRY_W)
    ) u_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (idx_reg),
        .rdata (rdata)
    );

    // Unpack the entry just read.
    assign rd_deadline = rdata[DL_LSB +: TIME_BITS];
    assign rd_id       = rdata[ID_LSB +: ID_W];
    assign rd_dest     = rdata[DEST_LSB +: DEST_W];
    assign rd_pay      = rdata[0 +: PAY_W];

    // Compare the entry against the key time and the request id.
    tdq_cmp #(
        .TIME_BITS (TIME_BITS)
    ) u_cmp (
        .entry_deadline (rd_deadline),
        .key_time       (key_reg),
        .entry_id       (rd_id),
        .match_id       (op_id_reg),
        .res            (cmp_res)
    );

    // Helpers for the scan.
    assign slot_free = !emit_valid_reg || emit_take;
    assign last_idx  = (CNT_W'(idx_reg) + CNT_W'(1)) == count_reg;
    assign found_now = found_reg || cmp_res.id_eq;
    assign fire_ok   = firing_reg && cmp_res.lt && (int'(fire_n_reg) < MAX_FIRE);

    // Next-state and datapath control.
    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        next_id_next    = next_id_reg;
        idx_next        = idx_reg;
        ins_addr_next   = ins_addr_reg;
        fire_n_next     = fire_n_reg;
        found_next      = found_reg;
        firing_next     = firing_reg;
        pend_next       = pend_reg;
        key_next        = key_reg;
        op_id_next      = op_id_reg;
        new_dest_next   = new_dest_reg;
        new_pay_next    = new_pay_reg;
        pend_id_next    = pend_id_reg;
        pend_dest_next  = pend_dest_reg;
        pend_pay_next   = pend_pay_reg;
        fin_item_next   = fin_item_reg;
        emit_valid_next = emit_valid_reg && !emit_take;
        emit_item_next  = emit_item_reg;
        mem_we          = 1'b0;
        mem_waddr       = idx_reg;
        mem_wdata       = rdata;

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    new_dest_next = s_item.destination;
                    new_pay_next  = s_item.payload;
                    fire_n_next   = '0;
                    found_next    = 1'b0;
                    firing_next   = 1'b1;
                    pend_next     = 1'b0;
                    idx_next      = '0;
                    if (s_item.opcode == OP_TICK) begin
                        key_next = TIME_BITS'(s_item.current_time);
                    end else begin
                        key_next = TIME_BITS'(s_item.deadline);
                    end
                    case (s_item.opcode)
                        OP_ADD: begin
                            if (count_reg == CNT_W'(CAPACITY)) begin
                                fin_item_next = tdq_result(ST_FULL, '0, '0, '0, 1'b1);
                                state_next    = S_FINISH;
                            end else begin
                                op_id_next   = next_id_reg;
                                next_id_next = next_id_reg + ID_W'(1);
                                if (count_reg == '0) begin
                                    ins_addr_next = '0;
                                    state_next    = S_AINS;
                                end else begin
                                    idx_next   = AW'(count_reg - CNT_W'(1));
                                    state_next = S_AREAD;
                                end
                            end
                        end
                        OP_DELETE: begin
                            op_id_next = s_item.target_id;
                            if (count_reg == '0) begin
                                fin_item_next = tdq_result(ST_NOTFOUND, s_item.target_id,
                                                           '0, '0, 1'b1);
                                state_next    = S_FINISH;
                            end else begin
                                state_next = S_DREAD;
                            end
                        end
                        OP_TICK: begin
                            if (count_reg != '0) begin
                                state_next = S_TREAD;
                            end
                        end
                        default: begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            // Insert: walk from the tail, moving later entries up by one.
            S_AREAD: begin
                state_next = S_AEVAL;
            end
            S_AEVAL: begin
                if (cmp_res.gt) begin
                    mem_we    = 1'b1;
                    mem_waddr = idx_reg + AW'(1);
                    if (idx_reg == '0) begin
                        ins_addr_next = '0;
                        state_next    = S_AINS;
                    end else begin
                        idx_next   = idx_reg - AW'(1);
                        state_next = S_AREAD;
                    end
                end else begin
                    ins_addr_next = idx_reg + AW'(1);
                    state_next    = S_AINS;
                end
            end
            S_AINS: begin
                mem_we        = 1'b1;
                mem_waddr     = ins_addr_reg;
                mem_wdata     = {key_reg, op_id_reg, new_dest_reg, new_pay_reg};
                count_next    = count_reg + CNT_W'(1);
                fin_item_next = tdq_result(ST_ADDED, op_id_reg, '0, '0, 1'b1);
                state_next    = S_FINISH;
            end

            // Delete: walk from the head; after the match, move entries down.
            S_DREAD: begin
                state_next = S_DEVAL;
            end
            S_DEVAL: begin
                if (found_reg) begin
                    mem_we    = 1'b1;
                    mem_waddr = idx_reg - AW'(1);
                end
                found_next = found_now;
                if (last_idx) begin
                    if (found_now) begin
                        count_next    = count_reg - CNT_W'(1);
                        fin_item_next = tdq_result(ST_DELETED, op_id_reg, '0, '0, 1'b1);
                    end else begin
                        fin_item_next = tdq_result(ST_NOTFOUND, op_id_reg, '0, '0, 1'b1);
                    end
                    state_next = S_FINISH;
                end else begin
                    idx_next   = idx_reg + AW'(1);
                    state_next = S_DREAD;
                end
            end

            // Tick: fire due head entries, holding one back to set last, then
            // move the remaining entries down by the number fired.
            S_TREAD: begin
                state_next = S_TEVAL;
            end
            S_TEVAL: begin
                if (fire_ok) begin
                    if (!pend_reg || slot_free) begin
                        if (pend_reg) begin
                            emit_valid_next = 1'b1;
                            emit_item_next  = tdq_result(ST_FIRED, pend_id_reg, pend_dest_reg,
                                                         pend_pay_reg, 1'b0);
                        end
                        pend_next      = 1'b1;
                        pend_id_next   = rd_id;
                        pend_dest_next = rd_dest;
                        pend_pay_next  = rd_pay;
                        fire_n_next    = fire_n_reg + CNT_W'(1);
                        if (last_idx) begin
                            state_next = S_TLAST;
                        end else begin
                            idx_next   = idx_reg + AW'(1);
                            state_next = S_TREAD;
                        end
                    end
                end else if (fire_n_reg == '0) begin
                    state_next = S_IDLE;
                end else if (!pend_reg || slot_free) begin
                    if (pend_reg) begin
                        emit_valid_next = 1'b1;
                        emit_item_next  = tdq_result(ST_FIRED, pend_id_reg, pend_dest_reg,
                                                     pend_pay_reg, 1'b1);
                    end
                    pend_next   = 1'b0;
                    firing_next = 1'b0;
                    mem_we      = 1'b1;
                    mem_waddr   = AW'(CNT_W'(idx_reg) - fire_n_reg);
                    if (last_idx) begin
                        count_next = count_reg - fire_n_reg;
                        state_next = S_IDLE;
                    end else begin
                        idx_next   = idx_reg + AW'(1);
                        state_next = S_TREAD;
                    end
                end
            end
            S_TLAST: begin
                if (slot_free) begin
                    emit_valid_next = 1'b1;
                    emit_item_next  = tdq_result(ST_FIRED, pend_id_reg, pend_dest_reg,
                                                 pend_pay_reg, 1'b1);
                    pend_next       = 1'b0;
                    count_next      = count_reg - fire_n_reg;
                    state_next      = S_IDLE;
                end
            end

            // Hand the single result of an add or delete to the output stage.
            S_FINISH: begin
                if (slot_free) begin
                    emit_valid_next = 1'b1;
                    emit_item_next  = fin_item_reg;
                    state_next      = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge aclk) begin
        idx_reg       <= idx_next;
        ins_addr_reg  <= ins_addr_next;
        key_reg       <= key_next;
        op_id_reg     <= op_id_next;
        new_dest_reg  <= new_dest_next;
        new_pay_reg   <= new_pay_next;
        pend_id_reg   <= pend_id_next;
        pend_dest_reg <= pend_dest_next;
        pend_pay_reg  <= pend_pay_next;
        fin_item_reg  <= fin_item_next;
        emit_item_reg <= emit_item_next;
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            next_id_reg    <= ID_W'(1);
            fire_n_reg     <= '0;
            found_reg      <= 1'b0;
            firing_reg     <= 1'b0;
            pend_reg       <= 1'b0;
            emit_valid_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            next_id_reg    <= next_id_next;
            fire_n_reg     <= fire_n_next;
            found_reg      <= found_next;
            firing_reg     <= firing_next;
            pend_reg       <= pend_next;
            emit_valid_reg <= emit_valid_next;
        end
    end

    assign s_ready    = (state_reg == S_IDLE);
    assign emit_valid = emit_valid_reg;
    assign emit_item  = emit_item_reg;

endmodule

/* rtl/deadline_sorted_timer_queue.sv */
// Deadline sorted timer queue. Holds up to CAPACITY timers in ascending deadline
// order in a single-port-read memory and serves one request at a time; s_ready is
// high only while the sequencer is idle. Each entry visited takes a read state (read
// address) and then a compare state on the registered read data. An add walks from
// the tail until it meets an entry whose deadline is not later, and a delete walks
// the whole queue. A tick on an empty queue does no walk, and one with nothing due
// reads only the head. A tick that fires walks the whole queue while it emits the
// fired entries and compacts the rest. A full queue rejects an add without a walk.
// Results leave through an output register, so the next request is taken while a
// result still waits on m_ready.
// Depends on tdq_pkg, tdq_ctrl and deadline_sorted_timer_queue_assert.svh.
`include "deadline_sorted_timer_queue_assert.svh"

module deadline_sorted_timer_queue
    import tdq_pkg::*;
#(
    parameter int CAPACITY  = DEF_CAPACITY,
    parameter int TIME_BITS = DEF_TIME_BITS
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  tdq_in_t  s_item,
    output logic     m_valid,
    input  logic     m_ready,
    output tdq_out_t m_item
);

    logic     emit_valid;
    tdq_out_t emit_item;
    logic     emit_take;
    logic     out_free;
    logic     m_valid_reg;
    tdq_out_t m_item_reg;

    // Request sequencer with its store and compare unit.
    tdq_ctrl #(
        .CAPACITY  (CAPACITY),
        .TIME_BITS (TIME_BITS)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .emit_valid (emit_valid),
        .emit_item  (emit_item),
        .emit_take  (emit_take)
    );

    // Output register: loads whenever it is empty or being drained.
    assign out_free  = !m_valid_reg || m_ready;
    assign emit_take = emit_valid && out_free;

    always_ff @(posedge aclk) begin
        if (emit_take) begin
            m_item_reg <= emit_item;
        end
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit_take) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    // A result handed over always shows up on the output next cycle.
    `TDQ_ASSERT_NEXT(a_emit_lands, aclk, aresetn, emit_take, m_valid)
    // Only fired results can be followed by more results of the same request.
    `TDQ_ASSERT_IMPL(a_single_last, aclk, aresetn, m_valid && (m_item.status != ST_FIRED), m_item.last)
    // A rejected add never reports an id.
    `TDQ_ASSERT_IMPL(a_full_no_id, aclk, aresetn, m_valid && (m_item.status == ST_FULL), m_item.result_id == 32'd0)

endmodule

/* tb/deadline_sorted_timer_queue_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the deadline sorted timer queue.
// Depends on tdq_pkg and the deadline_sorted_timer_queue top level only.
module deadline_sorted_timer_queue_tb;
    import tdq_pkg::*;

    localparam int          CAPACITY    = DEF_CAPACITY;
    localparam int          TIME_BITS   = DEF_TIME_BITS;
    localparam logic [63:0] TIME_MASK   = {64{1'b1}} >> (64 - TIME_BITS);
    localparam logic [1:0]  OP_UNUSED   = 2'd3;
    localparam int          CYCLE_LIMIT = 300000;
    localparam int          HOLD_CYCLES = 400;
    localparam int          DRAIN_WAIT  = 100;
    localparam int          RANDOM_REQS = 100;

    // One row of the directed table; known_result is used only where it is typed in.
    typedef struct {
        tdq_in_t  req;
        bit       has_known;
        tdq_out_t known_result;
    } directed_row_t;

    logic     aclk    = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    tdq_in_t  s_item  = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    tdq_out_t m_item;

    // Timer queue mirror, kept in ascending deadline order.
    logic [TIME_BITS-1:0] timer_deadline [CAPACITY];
    logic [ID_W-1:0]      timer_id       [CAPACITY];
    logic [DEST_W-1:0]    timer_dest     [CAPACITY];
    logic [PAY_W-1:0]     timer_param    [CAPACITY];
    int                   timer_count   = 0;
    logic [ID_W-1:0]      next_timer_id = 1;

    tdq_out_t step_results     [$];
    tdq_out_t expected_results [$];

    int error_count = 0;
    int cycle_count = 0;
    int burst_left  = 0;
    int hold_left   = 0;
    bit hold_done   = 1'b0;
    bit start_hold  = 1'b0;

    deadline_sorted_timer_queue #(
        .CAPACITY  (CAPACITY),
        .TIME_BITS (TIME_BITS)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Apply one accepted request to the mirror and collect the results it causes.
    task automatic timer_queue_step(input tdq_in_t req);
        logic [TIME_BITS-1:0] key;
        int                   pos;
        int                   fired;
        step_results.delete();
        case (req.opcode)
            OP_ADD: begin
                key = req.deadline & TIME_MASK[IN_TIME_W-1:0];
                if (timer_count >= CAPACITY) begin
                    step_results.push_back(tdq_out_t'{ST_FULL, '0, '0, '0, 1'b1});
                end else begin
                    // Insert ahead of the first strictly later deadline.
                    pos = timer_count;
                    for (int i = 0; i < timer_count; i++) begin
                        if (timer_deadline[i] > key) begin
                            pos = i;
                            break;
                        end
                    end
                    for (int i = timer_count; i > pos; i--) begin
                        timer_deadline[i] = timer_deadline[i-1];
                        timer_id[i]       = timer_id[i-1];
                        timer_dest[i]     = timer_dest[i-1];
                        timer_param[i]    = timer_param[i-1];
                    end
                    timer_deadline[pos] = key;
                    timer_id[pos]       = next_timer_id;
                    timer_dest[pos]     = req.destination;
                    timer_param[pos]    = req.payload;
                    timer_count++;
                    step_results.push_back(tdq_out_t'{ST_ADDED, next_timer_id, '0, '0, 1'b1});
                    next_timer_id = next_timer_id + 1;
                end
            end
            OP_DELETE: begin
                pos = 0;
                while (pos < timer_count && timer_id[pos] != req.target_id) pos++;
                if (pos >= timer_count) begin
                    step_results.push_back(
                        tdq_out_t'{ST_NOTFOUND, req.target_id, '0, '0, 1'b1});
                end else begin
                    for (int i = pos; i + 1 < timer_count; i++) begin
                        timer_deadline[i] = timer_deadline[i+1];
                        timer_id[i]       = timer_id[i+1];
                        timer_dest[i]     = timer_dest[i+1];
                        timer_param[i]    = timer_param[i+1];
                    end
                    timer_count--;
                    step_results.push_back(
                        tdq_out_t'{ST_DELETED, req.target_id, '0, '0, 1'b1});
                end
            end
            OP_TICK: begin
                key   = req.current_time & TIME_MASK[IN_TIME_W-1:0];
                fired = 0;
                while (fired < timer_count && fired < MAX_FIRE &&
                       timer_deadline[fired] < key) begin
                    step_results.push_back(tdq_out_t'{ST_FIRED, timer_id[fired],
                        timer_dest[fired], timer_param[fired], 1'b0});
                    fired++;
                end
                if (fired > 0) begin
                    step_results[fired-1].last = 1'b1;
                    for (int i = 0; i + fired < timer_count; i++) begin
                        timer_deadline[i] = timer_deadline[i+fired];
                        timer_id[i]       = timer_id[i+fired];
                        timer_dest[i]     = timer_dest[i+fired];
                        timer_param[i]    = timer_param[i+fired];
                    end
                    timer_count -= fired;
                end
            end
            default: begin
                // The unused opcode leaves the queue alone.
            end
        endcase
    endtask

    function automatic tdq_in_t make_request(input logic [1:0] op,
                                             input logic [IN_TIME_W-1:0] deadline,
                                             input logic [DEST_W-1:0] dest,
                                             input logic [PAY_W-1:0] pay,
                                             input logic [ID_W-1:0] tid,
                                             input logic [IN_TIME_W-1:0] now);
        tdq_in_t req;
        req.opcode       = op;
        req.deadline     = deadline;
        req.destination  = dest;
        req.payload      = pay;
        req.target_id    = tid;
        req.current_time = now;
        return req;
    endfunction

    function automatic logic [IN_TIME_W-1:0] random_time();
        return {16'($urandom()), 32'($urandom())};
    endfunction

    // All fields random, so the fields an opcode does not use carry noise too.
    function automatic tdq_in_t random_request(input logic [1:0] op);
        return make_request(op, random_time(), 16'($urandom()), $urandom(), $urandom(),
                            random_time());
    endfunction

    // Offer one request in the current burst, or after a gap once the burst is used up.
    task automatic send_request(input tdq_in_t req, input bit has_known,
                                input tdq_out_t known_result);
        int gap;
        if (burst_left == 0) begin
            s_valid <= 1'b0;
            gap = $urandom_range(1, 12);
            repeat (gap) @(posedge aclk);
            burst_left = $urandom_range(1, 16);
        end
        s_item  <= req;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        timer_queue_step(req);
        if (has_known) begin
            expected_results.push_back(known_result);
        end else begin
            foreach (step_results[i]) expected_results.push_back(step_results[i]);
        end
        burst_left--;
    endtask

    task automatic send_checked(input tdq_in_t req);
        send_request(req, 1'b0, '0);
    endtask

    task automatic check_result(input tdq_out_t got);
        tdq_out_t want;
        if (expected_results.size() == 0) begin
            $error("result with no request waiting: status %0d, id %0h",
                   got.status, got.result_id);
            error_count++;
        end else begin
            want = expected_results.pop_front();
            if (got.status !== want.status) begin
                $error("status: expected %0d, actual %0d", want.status, got.status);
                error_count++;
            end
            if (got.result_id !== want.result_id) begin
                $error("result_id: expected %0h, actual %0h", want.result_id, got.result_id);
                error_count++;
            end
            if (got.fired_destination !== want.fired_destination) begin
                $error("fired_destination: expected %0h, actual %0h",
                       want.fired_destination, got.fired_destination);
                error_count++;
            end
            if (got.fired_payload !== want.fired_payload) begin
                $error("fired_payload: expected %0h, actual %0h",
                       want.fired_payload, got.fired_payload);
                error_count++;
            end
            if (got.last !== want.last) begin
                $error("last: expected %0d, actual %0d", want.last, got.last);
                error_count++;
            end
        end
    endtask

    // Run limit.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Result side: check each handshake, then pick the next ready level.
    // One long hold-off lets the queue back up into the request side.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) check_result(m_item);
        if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left--;
        end else if (start_hold && !hold_done) begin
            m_ready   <= 1'b0;
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end else begin
            case (cycle_count[8:7])
                2'd0: m_ready <= 1'b1;
                2'd1: m_ready <= ($urandom_range(0, 3) != 0);
                2'd2: m_ready <= ($urandom_range(0, 9) < 3);
                default: m_ready <= (cycle_count % 3 == 0);
            endcase
        end
    end

    initial begin
        directed_row_t        directed_rows [$];
        tdq_in_t              req;
        logic [IN_TIME_W-1:0] time_base;
        logic [IN_TIME_W-1:0] shared_deadline;
        int                   sent;
        int                   fill_runs;
        int                   scenario;
        int                   pairs;

        // Directed table: empty queue, field extremes, equal deadlines, every opcode.
        directed_rows.push_back('{make_request(OP_TICK, '0, '0, '0, '0, '0), 1'b0, '0});
        directed_rows.push_back('{make_request(OP_DELETE, '0, '0, '0, '0, '0), 1'b1,
            tdq_out_t'{ST_NOTFOUND, 32'h0, '0, '0, 1'b1}});
        directed_rows.push_back('{make_request(OP_DELETE, '0, '0, '0, '1, '0), 1'b1,
            tdq_out_t'{ST_NOTFOUND, 32'hFFFF_FFFF, '0, '0, 1'b1}});
        directed_rows.push_back('{make_request(OP_ADD, '1, '1, '1, '0, '0), 1'b1,
            tdq_out_t'{ST_ADDED, 32'd1, '0, '0, 1'b1}});
        directed_rows.push_back('{make_request(OP_ADD, '0, '0, '0, '1, '1), 1'b1,
            tdq_out_t'{ST_ADDED, 32'd2, '0, '0, 1'b1}});
        directed_rows.push_back('{make_request(OP_ADD, 48'd100, 16'h1234, 32'hAAAA_5555,
            '0, '0), 1'b1, tdq_out_t'{ST_ADDED, 32'd3, '0, '0, 1'b1}});
        directed_rows.push_back('{make_request(OP_ADD, 48'd100, 16'h4321, 32'h5555_AAAA,
            '0, '0), 1'b1, tdq_out_t'{ST_ADDED, 32'd4, '0, '0, 1'b1}});
        directed_rows.push_back('{make_request(OP_ADD, 48'd50, 16'h00FF, 32'h0F0F_0F0F,
            '0, '0), 1'b1, tdq_out_t'{ST_ADDED, 32'd5, '0, '0, 1'b1}});
        directed_rows.push_back('{make_request(OP_TICK, '0, '0, '0, '0, 48'd0), 1'b0, '0});
        directed_rows.push_back('{make_request(OP_TICK, '0, '0, '0, '0, 48'd100), 1'b0, '0});
        directed_rows.push_back('{make_request(OP_TICK, '0, '0, '0, '0, 48'd101), 1'b0, '0});
        directed_rows.push_back('{make_request(OP_UNUSED, '1, '1, '1, '1, '1), 1'b0, '0});
        directed_rows.push_back('{make_request(OP_DELETE, '0, '0, '0, 32'd1, '0), 1'b1,
            tdq_out_t'{ST_DELETED, 32'd1, '0, '0, 1'b1}});
        directed_rows.push_back('{make_request(OP_DELETE, '0, '0, '0, 32'd1, '0), 1'b1,
            tdq_out_t'{ST_NOTFOUND, 32'd1, '0, '0, 1'b1}});
        directed_rows.push_back('{make_request(OP_ADD, 48'd10, 16'hBEEF, 32'h1357_9BDF,
            '0, '0), 1'b1, tdq_out_t'{ST_ADDED, 32'd6, '0, '0, 1'b1}});
        directed_rows.push_back('{make_request(OP_TICK, '0, '0, '0, '0, '1), 1'b0, '0});
        directed_rows.push_back('{make_request(OP_TICK, '0, '0, '0, '0, '1), 1'b0, '0});

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i]) begin
            send_request(directed_rows[i].req, directed_rows[i].has_known,
                         directed_rows[i].known_result);
        end

        // Random part; the long receiver hold-off starts with it.
        start_hold <= 1'b1;
        time_base = 48'd1000;
        sent      = 0;
        fill_runs = 0;
        while (sent < RANDOM_REQS) begin
            scenario = $urandom_range(0, 19);
            if (scenario < 2 && fill_runs < 2) begin
                // Fill to capacity, one rejected add, then a tick that drains the queue.
                fill_runs++;
                while (timer_count < CAPACITY) begin
                    req = random_request(OP_ADD);
                    req.deadline = time_base + $urandom_range(0, 400);
                    send_checked(req);
                    sent++;
                end
                send_checked(random_request(OP_ADD));
                req = random_request(OP_TICK);
                req.current_time = '1;
                send_checked(req);
                sent += 2;
            end else if (scenario < 8) begin
                req = random_request(OP_ADD);
                req.deadline = time_base + $urandom_range(0, 400);
                send_checked(req);
                sent++;
            end else if (scenario < 10) begin
                // Several timers on one deadline must fire in arrival order.
                shared_deadline = time_base + $urandom_range(0, 200);
                pairs = $urandom_range(2, 3);
                repeat (pairs) begin
                    req = random_request(OP_ADD);
                    req.deadline = shared_deadline;
                    send_checked(req);
                    sent++;
                end
            end else if (scenario < 13) begin
                req = random_request(OP_DELETE);
                if (timer_count > 0) begin
                    req.target_id = timer_id[$urandom_range(0, timer_count - 1)];
                end
                send_checked(req);
                sent++;
            end else if (scenario < 17) begin
                time_base = time_base + $urandom_range(0, 150);
                req = random_request(OP_TICK);
                req.current_time = time_base;
                send_checked(req);
                sent++;
            end else if (scenario == 17) begin
                send_checked(random_request(OP_UNUSED));
                sent++;
            end else begin
                // Noise: random id, far deadline or arbitrary time.
                case ($urandom_range(0, 2))
                    0: send_checked(random_request(OP_DELETE));
                    1: send_checked(random_request(OP_ADD));
                    default: send_checked(random_request(OP_TICK));
                endcase
                sent++;
            end
        end
        s_valid <= 1'b0;

        while (expected_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
